[hw/rtl/mep_pkg.sv]
// ----------------------------------------------------------------------------
// mep_pkg
// Shared types and constants for the Mandelbrot escape-time pixel evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package mep_pkg;

  localparam int unsigned DEF_WIDTH     = 1024;
  localparam int unsigned DEF_HEIGHT    = 1024;
  localparam int unsigned DEF_FRAC_BITS = 28;

  localparam int unsigned INT_BITS = 4;
  localparam int unsigned COORD_W  = 10;
  localparam int unsigned LIMIT_W  = 12;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd1000;

  typedef enum logic [1:0] {
    REG_LIMIT   = 2'd0,
    REG_RED     = 2'd1,
    REG_GREEN   = 2'd2,
    REG_BLUE    = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    PROD_XX = 2'd0,
    PROD_YY = 2'd1,
    PROD_XY = 2'd2
  } prod_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_DIV_RE = 3'd1,
    ST_DIV_IM = 3'd2,
    ST_LAUNCH = 3'd3,
    ST_MUL    = 3'd4,
    ST_CHECK  = 3'd5,
    ST_FINISH = 3'd6
  } state_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } color_t;

endpackage

`default_nettype wire

[hw/rtl/mandelbrot_escape_pixel.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel
// Escape-time evaluator for one pixel: maps the pixel to a point c, iterates
// z = z*z + c in signed fixed point and colors the pixel by its escape count.
//
//   Channel   Signals                                  Direction
//   config    psel penable pwrite paddr pwdata         in, APB write and read
//             prdata pready                            out
//   pixel     start column_i line_i / busy             in, taken on start & !busy
//   result    done_o red_o green_o blue_o              out, one-cycle strobe
//             escape_count_o inside_set_o
//
// Each coordinate mapping runs through the pipelined constant divider, real
// part first and imaginary part second. Each iteration then feeds twelve
// partial products through the single half-width multiplier. A transaction
// keeps busy high from an accepted start until the result is shown.
// Reset clears the sequencer and loads the register defaults; the receiver
// cannot stall, and the result is shown for one cycle as busy falls.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_pixel #(
  parameter int unsigned WIDTH     = mep_pkg::DEF_WIDTH,
  parameter int unsigned HEIGHT    = mep_pkg::DEF_HEIGHT,
  parameter int unsigned FRAC_BITS = mep_pkg::DEF_FRAC_BITS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mep_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [mep_pkg::DATA_W-1:0]  pwdata,
  output logic [mep_pkg::DATA_W-1:0]       prdata,
  output logic                             pready,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [mep_pkg::COORD_W-1:0] column_i,
  input  wire logic [mep_pkg::COORD_W-1:0] line_i,
  output logic                             done_o,
  output logic [mep_pkg::CHAN_W-1:0]       red_o,
  output logic [mep_pkg::CHAN_W-1:0]       green_o,
  output logic [mep_pkg::CHAN_W-1:0]       blue_o,
  output logic [mep_pkg::LIMIT_W-1:0]      escape_count_o,
  output logic                             inside_set_o
);

  localparam int unsigned N  = FRAC_BITS + mep_pkg::INT_BITS;
  localparam int unsigned PW = 2 * N;
  localparam int unsigned SW = PW - FRAC_BITS + 1;
  localparam int unsigned XL = FRAC_BITS + N - 1;
  localparam logic [SW-1:0] FOUR = SW'(4) << FRAC_BITS;

  mep_pkg::state_e state_q, state_d;

  logic [mep_pkg::LIMIT_W-1:0] limit_q;
  logic [mep_pkg::CHAN_W-1:0]  red_off_q;
  logic [mep_pkg::CHAN_W-1:0]  green_off_q;
  logic [mep_pkg::CHAN_W-1:0]  blue_off_q;
  mep_pkg::reg_e               reg_idx;
  logic                        cfg_wr;

  logic [mep_pkg::COORD_W-1:0] line_q;
  logic [N-1:0]                cre_q;
  logic [N-1:0]                cim_q;
  logic [N-1:0]                x_q;
  logic [N-1:0]                y_q;
  logic [mep_pkg::LIMIT_W-1:0] n_q;

  logic                        done_q;
  mep_pkg::color_t             color_q;
  logic [mep_pkg::LIMIT_W-1:0] count_q;
  logic                        inside_q;

  logic                        accept;
  logic                        div_start;
  logic                        div_is_im;
  logic [mep_pkg::COORD_W-1:0] div_pos;
  logic                        div_done;
  logic [N-1:0]                div_c;
  logic                        mac_start;
  logic                        mac_done;
  logic [PW-1:0]               xx;
  logic [PW-1:0]               yy;
  logic [PW-1:0]               xym;
  logic                        xy_neg;

  logic [SW-1:0]               mag2;
  logic                        escaped;
  logic [XL-1:0]               xy_lo;
  logic [XL-1:0]               xy_s;
  logic [N-1:0]                nx;
  logic [N-1:0]                ny;
  logic [mep_pkg::LIMIT_W-1:0] n_inc;
  logic                        at_limit;
  logic                        in_set;
  mep_pkg::color_t             color;

  // Configuration port.
  assign reg_idx = mep_pkg::reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    case (reg_idx)
      mep_pkg::REG_LIMIT: prdata = mep_pkg::DATA_W'(limit_q);
      mep_pkg::REG_RED:   prdata = mep_pkg::DATA_W'(red_off_q);
      mep_pkg::REG_GREEN: prdata = mep_pkg::DATA_W'(green_off_q);
      default:            prdata = mep_pkg::DATA_W'(blue_off_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= mep_pkg::LIMIT_RESET;
      red_off_q   <= '0;
      green_off_q <= '0;
      blue_off_q  <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        mep_pkg::REG_LIMIT: limit_q     <= pwdata[mep_pkg::LIMIT_W-1:0];
        mep_pkg::REG_RED:   red_off_q   <= pwdata[mep_pkg::CHAN_W-1:0];
        mep_pkg::REG_GREEN: green_off_q <= pwdata[mep_pkg::CHAN_W-1:0];
        default:            blue_off_q  <= pwdata[mep_pkg::CHAN_W-1:0];
      endcase
    end
  end

  mep_cdiv #(
    .WIDTH     (WIDTH),
    .HEIGHT    (HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) u_cdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .is_im_i (div_is_im),
    .pos_i   (div_pos),
    .done_o  (div_done),
    .c_o     (div_c)
  );

  mep_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mac_start),
    .x_i      (x_q),
    .y_i      (y_q),
    .done_o   (mac_done),
    .xx_o     (xx),
    .yy_o     (yy),
    .xym_o    (xym),
    .xy_neg_o (xy_neg)
  );

  mep_color u_color (
    .count_i     (n_q),
    .inside_i    (in_set),
    .red_off_i   (red_off_q),
    .green_off_i (green_off_q),
    .blue_off_i  (blue_off_q),
    .color_o     (color)
  );

  // Escape test and next point.
  always_comb begin
    mag2     = SW'(xx[PW-1:FRAC_BITS]) + SW'(yy[PW-1:FRAC_BITS]);
    escaped  = mag2 > FOUR;
    xy_lo    = xym[XL-1:0];
    xy_s     = xy_neg ? (XL'(0) - xy_lo) : xy_lo;
    nx       = xx[FRAC_BITS+N-1:FRAC_BITS] - yy[FRAC_BITS+N-1:FRAC_BITS] + cre_q;
    ny       = xy_s[XL-1:FRAC_BITS-1] + cim_q;
    n_inc    = n_q + mep_pkg::LIMIT_W'(1);
    at_limit = n_inc >= limit_q;
    in_set   = n_q >= limit_q;
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mep_pkg::ST_IDLE: begin
        if (start) begin
          state_d = mep_pkg::ST_DIV_RE;
        end
      end
      mep_pkg::ST_DIV_RE: begin
        if (div_done) begin
          state_d = mep_pkg::ST_DIV_IM;
        end
      end
      mep_pkg::ST_DIV_IM: begin
        if (div_done) begin
          state_d = (limit_q == '0) ? mep_pkg::ST_FINISH : mep_pkg::ST_LAUNCH;
        end
      end
      mep_pkg::ST_LAUNCH: state_d = mep_pkg::ST_MUL;
      mep_pkg::ST_MUL: begin
        if (mac_done) begin
          state_d = mep_pkg::ST_CHECK;
        end
      end
      mep_pkg::ST_CHECK: begin
        if (escaped || at_limit) begin
          state_d = mep_pkg::ST_FINISH;
        end else begin
          state_d = mep_pkg::ST_LAUNCH;
        end
      end
      mep_pkg::ST_FINISH: state_d = mep_pkg::ST_IDLE;
      default:            state_d = mep_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy      = state_q != mep_pkg::ST_IDLE;
    accept    = start && !busy;
    div_is_im = state_q == mep_pkg::ST_DIV_RE;
    div_start = accept || (div_is_im && div_done);
    div_pos   = div_is_im ? line_q : column_i;
    mac_start = state_q == mep_pkg::ST_LAUNCH;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mep_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= state_q == mep_pkg::ST_FINISH;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_q <= line_i;
    end
    if (div_is_im && div_done) begin
      cre_q <= div_c;
    end
    if (state_q == mep_pkg::ST_DIV_IM && div_done) begin
      cim_q <= div_c;
      x_q   <= '0;
      y_q   <= '0;
      n_q   <= '0;
    end
    if (state_q == mep_pkg::ST_CHECK && !escaped) begin
      x_q <= nx;
      y_q <= ny;
      n_q <= n_inc;
    end
    if (state_q == mep_pkg::ST_FINISH) begin
      color_q  <= color;
      count_q  <= n_q;
      inside_q <= in_set;
    end
  end

  assign done_o         = done_q;
  assign red_o          = color_q.red;
  assign green_o        = color_q.green;
  assign blue_o         = color_q.blue;
  assign escape_count_o = count_q;
  assign inside_set_o   = inside_q;

endmodule

`default_nettype wire

[hw/rtl/mep_cdiv.sv]
// ----------------------------------------------------------------------------
// mep_cdiv
// Maps a pixel coordinate to a fixed-point point of the complex plane. The
// division by the constant image width is a shift by its power-of-two factor
// and a reciprocal multiplication by its odd factor, split into registered steps.
// ----------------------------------------------------------------------------
`default_nettype none

module mep_cdiv #(
  parameter int unsigned WIDTH     = mep_pkg::DEF_WIDTH,
  parameter int unsigned HEIGHT    = mep_pkg::DEF_HEIGHT,
  parameter int unsigned FRAC_BITS = mep_pkg::DEF_FRAC_BITS
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     start_i,
  input  wire logic                                     is_im_i,
  input  wire logic [mep_pkg::COORD_W-1:0]              pos_i,
  output logic                                          done_o,
  output logic [FRAC_BITS+mep_pkg::INT_BITS-1:0]        c_o
);

  localparam int unsigned N        = FRAC_BITS + mep_pkg::INT_BITS;
  localparam int unsigned TWICE_W  = mep_pkg::COORD_W + 1;
  localparam int unsigned POS_TOP  = 2 * ((2 ** mep_pkg::COORD_W) - 1);
  localparam int unsigned SPAN_BIG = (WIDTH > HEIGHT) ? WIDTH : HEIGHT;
  localparam int unsigned SPAN_TOP = (SPAN_BIG > POS_TOP) ? SPAN_BIG : POS_TOP;
  localparam int unsigned MAG_W    = $clog2(SPAN_TOP + 1);

  // The width is split into 2^W_EXP times an odd factor W_ODD.
  localparam int unsigned     LOW_BIT = WIDTH & (~WIDTH + 1);
  localparam int unsigned     W_EXP   = $clog2(LOW_BIT);
  localparam int unsigned     W_ODD   = WIDTH >> W_EXP;
  localparam longint unsigned SCALE   = 64'd1 << (FRAC_BITS + 1 - W_EXP);
  localparam longint unsigned Q_INT   = SCALE / 64'(W_ODD);
  localparam longint unsigned Q_REM   = SCALE % 64'(W_ODD);
  localparam int unsigned     RBW     = $clog2(WIDTH) + 1;
  localparam int unsigned     VW      = MAG_W + RBW;
  localparam int unsigned     SH      = VW + $clog2(W_ODD);
  localparam int unsigned     MW      = VW + 1;
  localparam int unsigned     PRW     = VW + MW;
  localparam longint unsigned RECIP   =
      ((64'd1 << SH) + 64'(W_ODD) - 64'd1) / 64'(W_ODD);
  localparam logic [N-1:0]    Q_INT_N = N'(Q_INT);
  localparam logic [RBW-1:0]  Q_REM_R = RBW'(Q_REM);
  localparam logic [MW-1:0]   RECIP_M = MW'(RECIP);

  logic [TWICE_W-1:0] twice;
  logic [MAG_W-1:0]   twice_x;
  logic [MAG_W-1:0]   span;
  logic               neg;
  logic [MAG_W-1:0]   mag;
  logic [PRW-1:0]     lo_prod;
  logic [N-1:0]       quo;

  logic [MAG_W-1:0]   mag_q;
  logic               neg_q;
  logic [N-1:0]       hi_q;
  logic [VW-1:0]      rem_q;
  logic [N-1:0]       lo_q;
  logic [2:0]         stage_q;

  assign twice   = {pos_i, 1'b0};
  assign twice_x = MAG_W'(twice);
  assign span    = is_im_i ? MAG_W'(HEIGHT) : MAG_W'(WIDTH);
  assign neg     = twice_x < span;
  assign mag     = neg ? (span - twice_x) : (twice_x - span);

  assign lo_prod = PRW'(rem_q) * PRW'(RECIP_M);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= {stage_q[1:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= mag;
      neg_q <= neg;
    end
    if (stage_q[0]) begin
      hi_q  <= N'(mag_q) * Q_INT_N;
      rem_q <= VW'(mag_q) * VW'(Q_REM_R);
    end
    if (stage_q[1]) begin
      lo_q <= N'(lo_prod >> SH);
    end
  end

  assign quo    = hi_q + lo_q;
  assign done_o = stage_q[2];
  assign c_o    = neg_q ? (N'(0) - quo) : quo;

endmodule

`default_nettype wire

[hw/rtl/mep_mac.sv]
// ----------------------------------------------------------------------------
// mep_mac
// Shared half-width multiplier with an accumulator that forms the squares of
// x and y and the magnitude of x*y from four partial products each.
// ----------------------------------------------------------------------------
`default_nettype none

module mep_mac #(
  parameter int unsigned FRAC_BITS = mep_pkg::DEF_FRAC_BITS
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          start_i,
  input  wire logic [FRAC_BITS+mep_pkg::INT_BITS-1:0]        x_i,
  input  wire logic [FRAC_BITS+mep_pkg::INT_BITS-1:0]        y_i,
  output logic                                               done_o,
  output logic [2*(FRAC_BITS+mep_pkg::INT_BITS)-1:0]         xx_o,
  output logic [2*(FRAC_BITS+mep_pkg::INT_BITS)-1:0]         yy_o,
  output logic [2*(FRAC_BITS+mep_pkg::INT_BITS)-1:0]         xym_o,
  output logic                                               xy_neg_o
);

  localparam int unsigned N  = FRAC_BITS + mep_pkg::INT_BITS;
  localparam int unsigned H  = (N + 1) / 2;
  localparam int unsigned PW = 2 * N;
  localparam logic [3:0] LAST_STEP = 4'd11;

  logic [N-1:0]    xm_q;
  logic [N-1:0]    ym_q;
  logic            xy_neg_q;
  logic            run_q;
  logic [3:0]      step_q;

  logic            tag_vld_q;
  mep_pkg::prod_e  tag_prod_q;
  logic            tag_first_q;
  logic            tag_last_q;
  logic [1:0]      tag_sh_q;
  logic [2*H-1:0]  mul_q;
  logic            done_q;

  logic [PW-1:0]   xx_q;
  logic [PW-1:0]   yy_q;
  logic [PW-1:0]   xy_q;

  mep_pkg::prod_e  prod;
  logic [N-1:0]    opa;
  logic [N-1:0]    opb;
  logic [H-1:0]    pa;
  logic [H-1:0]    pb;
  logic [PW-1:0]   addend;
  logic [PW-1:0]   cur;
  logic [PW-1:0]   acc_sum;

  always_comb begin
    prod = mep_pkg::prod_e'(step_q[3:2]);
    opa  = (prod == mep_pkg::PROD_YY) ? ym_q : xm_q;
    opb  = (prod == mep_pkg::PROD_XX) ? xm_q : ym_q;
    pa   = step_q[1] ? H'(opa >> H) : opa[H-1:0];
    pb   = step_q[0] ? H'(opb >> H) : opb[H-1:0];
  end

  always_comb begin
    case (tag_sh_q)
      2'd0:    addend = PW'(mul_q);
      2'd1:    addend = PW'(mul_q) << H;
      default: addend = PW'(mul_q) << (2 * H);
    endcase
    case (tag_prod_q)
      mep_pkg::PROD_XX: cur = xx_q;
      mep_pkg::PROD_YY: cur = yy_q;
      default:          cur = xy_q;
    endcase
    acc_sum = (tag_first_q ? '0 : cur) + addend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= 1'b0;
      step_q    <= '0;
      tag_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      tag_vld_q <= run_q;
      done_q    <= tag_vld_q && tag_last_q;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        run_q  <= (step_q != LAST_STEP);
        step_q <= step_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      xm_q     <= x_i[N-1] ? (N'(0) - x_i) : x_i;
      ym_q     <= y_i[N-1] ? (N'(0) - y_i) : y_i;
      xy_neg_q <= x_i[N-1] ^ y_i[N-1];
    end
    mul_q       <= pa * pb;
    tag_prod_q  <= prod;
    tag_first_q <= (step_q[1:0] == 2'd0);
    tag_last_q  <= (step_q == LAST_STEP);
    tag_sh_q    <= {1'b0, step_q[1]} + {1'b0, step_q[0]};
    if (tag_vld_q) begin
      case (tag_prod_q)
        mep_pkg::PROD_XX: xx_q <= acc_sum;
        mep_pkg::PROD_YY: yy_q <= acc_sum;
        default:          xy_q <= acc_sum;
      endcase
    end
  end

  assign done_o   = done_q;
  assign xx_o     = xx_q;
  assign yy_o     = yy_q;
  assign xym_o    = xy_q;
  assign xy_neg_o = xy_neg_q;

endmodule

`default_nettype wire

[hw/rtl/mep_color.sv]
// ----------------------------------------------------------------------------
// mep_color
// Maps an escape count onto the blue, green and red color ramp and adds the
// per-channel offsets; points inside the set and a count of zero give black.
// ----------------------------------------------------------------------------
`default_nettype none

module mep_color (
  input  wire logic [mep_pkg::LIMIT_W-1:0] count_i,
  input  wire logic                        inside_i,
  input  wire logic [mep_pkg::CHAN_W-1:0]  red_off_i,
  input  wire logic [mep_pkg::CHAN_W-1:0]  green_off_i,
  input  wire logic [mep_pkg::CHAN_W-1:0]  blue_off_i,
  output mep_pkg::color_t                  color_o
);

  logic [mep_pkg::LIMIT_W-1:0] k;
  logic [mep_pkg::CHAN_W-1:0]  lo;
  logic [mep_pkg::CHAN_W-1:0]  r;
  logic [mep_pkg::CHAN_W-1:0]  g;
  logic [mep_pkg::CHAN_W-1:0]  b;

  always_comb begin
    k  = count_i - mep_pkg::LIMIT_W'(1);
    lo = k[mep_pkg::CHAN_W-1:0];
    r  = '0;
    g  = '0;
    b  = '0;
    if (k[mep_pkg::LIMIT_W-1:9] != '0) begin
      r = lo;
      g = ~lo;
    end else if (k[8]) begin
      g = lo;
      b = ~lo;
    end else begin
      b = lo;
    end
    if (inside_i || (count_i == '0)) begin
      color_o = '0;
    end else begin
      color_o.red   = r + red_off_i;
      color_o.green = g + green_off_i;
      color_o.blue  = b + blue_off_i;
    end
  end

endmodule

`default_nettype wire
